FILE: src/bvh_thq_pkg.sv
// Shared types, constants and helpers of the terrain height query block.
`default_nettype none

package bvh_thq_pkg;

    localparam int CW    = 24;  // coordinate width
    localparam int IW    = 12;  // node / triangle entry index width
    localparam int LW    = 13;  // leaf triangle range width
    localparam int DW    = 52;  // width of the cross products
    localparam int MW    = 27;  // multiplier operand width
    localparam int PW    = 54;  // multiplier product width
    localparam int NW    = 80;  // numerator width of the height division
    localparam int SPLIT = 26;  // low half width of a split cross product
    localparam int QW    = 41;  // width of the capped quotient magnitude

    localparam logic [1:0] ACT_NODE   = 2'd0;
    localparam logic [1:0] ACT_CORNER = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;

    localparam logic [63:0]   QCAP    = 64'h0000_0100_0000_0000;
    localparam logic [QW-1:0] QCAP_QW = {1'b1, {(QW-1){1'b0}}};

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic          axis;
        logic [IW-1:0] child;
        logic [LW-1:0] stop;
        logic [LW-1:0] first;
        t_coord        hi;
        t_coord        lo;
    } t_node;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord az;
        t_coord bx;
        t_coord by;
        t_coord bz;
        t_coord cx;
        t_coord cy;
        t_coord cz;
    } t_tri;

    typedef struct packed {
        logic   done;
        logic   hit;
        t_coord height;
    } t_tri_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LINK,
        S_CH0,
        S_CH1,
        S_POP,
        S_SRD,
        S_TRD,
        S_TRI,
        S_DONE
    } t_top_state;

    typedef enum logic [2:0] {
        T_IDLE,
        T_MUL,
        T_CHK,
        T_DIV,
        T_RND,
        T_SUM
    } t_tri_state;

    function automatic logic signed [CW:0] sub_ext(input t_coord a, input t_coord b);
        logic signed [CW:0] r;
        r = {a[CW-1], a} - {b[CW-1], b};
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/bvh_thq_tri.sv
// Triangle unit: edge tests, plane height and rounded restoring division.
`default_nettype none

module bvh_thq_tri (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire bvh_thq_pkg::t_tri     i_tri,
    input  wire bvh_thq_pkg::t_coord   i_px,
    input  wire bvh_thq_pkg::t_coord   i_py,
    output bvh_thq_pkg::t_tri_res      o_res
);

    localparam int CW    = bvh_thq_pkg::CW;
    localparam int DW    = bvh_thq_pkg::DW;
    localparam int MW    = bvh_thq_pkg::MW;
    localparam int PW    = bvh_thq_pkg::PW;
    localparam int NW    = bvh_thq_pkg::NW;
    localparam int SPLIT = bvh_thq_pkg::SPLIT;
    localparam int QW    = bvh_thq_pkg::QW;

    // multiply sequence: each step feeds one product into one accumulator
    localparam logic [3:0] ST_E1P = 4'd0;
    localparam logic [3:0] ST_E1M = 4'd1;
    localparam logic [3:0] ST_D1P = 4'd2;
    localparam logic [3:0] ST_D1M = 4'd3;
    localparam logic [3:0] ST_D2P = 4'd4;
    localparam logic [3:0] ST_D2M = 4'd5;
    localparam logic [3:0] ST_D3P = 4'd6;
    localparam logic [3:0] ST_D3M = 4'd7;
    localparam logic [3:0] ST_NZP = 4'd8;
    localparam logic [3:0] ST_NZM = 4'd9;
    localparam logic [3:0] ST_NHA = 4'd10;
    localparam logic [3:0] ST_NLA = 4'd11;
    localparam logic [3:0] ST_NHB = 4'd12;
    localparam logic [3:0] ST_NLB = 4'd13;
    localparam logic [3:0] ST_END = 4'd14;

    bvh_thq_pkg::t_tri_state r_state, n_state;

    logic signed [CW:0]   r_abx, r_aby, r_abz, r_acx, r_acy, r_acz;
    logic signed [CW:0]   r_bcx, r_bcy, r_dx, r_dy, r_pbx, r_pby, r_pcx, r_pcy;
    bvh_thq_pkg::t_coord  r_az;
    logic [3:0]           r_step, r_tag;
    logic                 r_pvalid;
    logic signed [PW-1:0] r_prod;
    logic signed [DW-1:0] r_e1, r_d1, r_d2, r_d3, r_nz;
    logic signed [NW-1:0] r_num;
    logic [NW-1:0]        r_nq;
    logic [DW-1:0]        r_rem, r_den;
    logic                 r_neg;
    logic [6:0]           r_cnt;
    logic [QW-1:0]        r_qm;
    logic                 r_done, r_hit;
    bvh_thq_pkg::t_coord  r_height;

    logic w_ld, w_mul, w_chk, w_div, w_rnd_en, w_sum;
    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_mul_p;
    logic signed [DW-1:0] w_e2, w_pa;
    logic signed [NW-1:0] w_pn;
    logic                 w_in, w_pass;
    logic [NW-1:0]        w_num_mag;
    logic [DW-1:0]        w_nz_mag;
    logic [DW:0]          w_sh, w_rem_n;
    logic                 w_ge, w_rnd, w_big, w_cap;
    logic [63:0]          w_qlo;
    logic signed [QW:0]   w_qs;
    logic signed [QW+1:0] w_z;

    assign w_e2    = -r_d1;
    assign w_pa    = DW'(r_prod);
    assign w_pn    = NW'(r_prod);
    assign w_mul_p = w_ma * w_mb;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_step)
            ST_E1P: begin w_ma = MW'(r_dx);  w_mb = MW'(r_acy); end
            ST_E1M: begin w_ma = MW'(r_dy);  w_mb = MW'(r_acx); end
            ST_D1P: begin w_ma = MW'(r_aby); w_mb = MW'(r_dx);  end
            ST_D1M: begin w_ma = MW'(r_abx); w_mb = MW'(r_dy);  end
            ST_D2P: begin w_ma = MW'(r_bcy); w_mb = MW'(r_pbx); end
            ST_D2M: begin w_ma = MW'(r_bcx); w_mb = MW'(r_pby); end
            ST_D3P: begin w_ma = MW'(r_acx); w_mb = MW'(r_pcy); end
            ST_D3M: begin w_ma = MW'(r_acy); w_mb = MW'(r_pcx); end
            ST_NZP: begin w_ma = MW'(r_abx); w_mb = MW'(r_acy); end
            ST_NZM: begin w_ma = MW'(r_aby); w_mb = MW'(r_acx); end
            ST_NHA: begin
                w_ma = MW'(r_abz);
                w_mb = MW'($signed(r_e1[DW-1:SPLIT]));
            end
            ST_NLA: begin w_ma = MW'(r_abz); w_mb = {1'b0, r_e1[SPLIT-1:0]}; end
            ST_NHB: begin
                w_ma = MW'(r_acz);
                w_mb = MW'($signed(w_e2[DW-1:SPLIT]));
            end
            ST_NLB: begin w_ma = MW'(r_acz); w_mb = {1'b0, w_e2[SPLIT-1:0]}; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    // inclusive edge test, either winding
    assign w_in   = ((r_d1 <= 0) && (r_d2 <= 0) && (r_d3 <= 0)) ||
                    ((r_d1 >= 0) && (r_d2 >= 0) && (r_d3 >= 0));
    assign w_pass = w_in && (r_nz != '0);

    assign w_num_mag = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
    assign w_nz_mag  = r_nz[DW-1] ? DW'(-r_nz) : DW'(r_nz);

    assign w_sh    = {r_rem, r_nq[NW-1]};
    assign w_ge    = w_sh >= {1'b0, r_den};
    assign w_rem_n = w_ge ? (w_sh - {1'b0, r_den}) : w_sh;

    assign w_rnd = {r_rem, 1'b0} >= {1'b0, r_den};
    assign w_big = |r_nq[NW-1:64];
    assign w_qlo = r_nq[63:0] + 64'(w_rnd);
    assign w_cap = w_big || (w_qlo > bvh_thq_pkg::QCAP);

    assign w_qs = r_neg ? -$signed({1'b0, r_qm}) : $signed({1'b0, r_qm});
    assign w_z  = (QW+2)'(r_az) + (QW+2)'(w_qs);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bvh_thq_pkg::T_IDLE: if (i_start) n_state = bvh_thq_pkg::T_MUL;
            bvh_thq_pkg::T_MUL:  if (r_step == ST_END) n_state = bvh_thq_pkg::T_CHK;
            bvh_thq_pkg::T_CHK:  n_state = w_pass ? bvh_thq_pkg::T_DIV : bvh_thq_pkg::T_IDLE;
            bvh_thq_pkg::T_DIV:  if (r_cnt == 7'(NW-1)) n_state = bvh_thq_pkg::T_RND;
            bvh_thq_pkg::T_RND:  n_state = bvh_thq_pkg::T_SUM;
            bvh_thq_pkg::T_SUM:  n_state = bvh_thq_pkg::T_IDLE;
            default:             n_state = bvh_thq_pkg::T_IDLE;
        endcase
    end

    always_comb begin
        w_ld     = (r_state == bvh_thq_pkg::T_IDLE) && i_start;
        w_mul    = (r_state == bvh_thq_pkg::T_MUL) && (r_step != ST_END);
        w_chk    = (r_state == bvh_thq_pkg::T_CHK);
        w_div    = (r_state == bvh_thq_pkg::T_DIV);
        w_rnd_en = (r_state == bvh_thq_pkg::T_RND);
        w_sum    = (r_state == bvh_thq_pkg::T_SUM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bvh_thq_pkg::T_IDLE;
            r_done   <= 1'b0;
            r_pvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done   <= (w_chk && !w_pass) || w_sum;
            r_pvalid <= w_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_abx  <= bvh_thq_pkg::sub_ext(i_tri.bx, i_tri.ax);
            r_aby  <= bvh_thq_pkg::sub_ext(i_tri.by, i_tri.ay);
            r_abz  <= bvh_thq_pkg::sub_ext(i_tri.bz, i_tri.az);
            r_acx  <= bvh_thq_pkg::sub_ext(i_tri.cx, i_tri.ax);
            r_acy  <= bvh_thq_pkg::sub_ext(i_tri.cy, i_tri.ay);
            r_acz  <= bvh_thq_pkg::sub_ext(i_tri.cz, i_tri.az);
            r_bcx  <= bvh_thq_pkg::sub_ext(i_tri.cx, i_tri.bx);
            r_bcy  <= bvh_thq_pkg::sub_ext(i_tri.cy, i_tri.by);
            r_dx   <= bvh_thq_pkg::sub_ext(i_px, i_tri.ax);
            r_dy   <= bvh_thq_pkg::sub_ext(i_py, i_tri.ay);
            r_pbx  <= bvh_thq_pkg::sub_ext(i_px, i_tri.bx);
            r_pby  <= bvh_thq_pkg::sub_ext(i_py, i_tri.by);
            r_pcx  <= bvh_thq_pkg::sub_ext(i_px, i_tri.cx);
            r_pcy  <= bvh_thq_pkg::sub_ext(i_py, i_tri.cy);
            r_az   <= i_tri.az;
            r_step <= ST_E1P;
        end
        if (w_mul) begin
            r_prod <= w_mul_p;
            r_tag  <= r_step;
            r_step <= r_step + 4'd1;
        end
        if (r_pvalid) begin
            case (r_tag)
                ST_E1P:  r_e1  <= w_pa;
                ST_E1M:  r_e1  <= r_e1 - w_pa;
                ST_D1P:  r_d1  <= w_pa;
                ST_D1M:  r_d1  <= r_d1 - w_pa;
                ST_D2P:  r_d2  <= w_pa;
                ST_D2M:  r_d2  <= r_d2 - w_pa;
                ST_D3P:  r_d3  <= w_pa;
                ST_D3M:  r_d3  <= r_d3 - w_pa;
                ST_NZP:  r_nz  <= w_pa;
                ST_NZM:  r_nz  <= r_nz - w_pa;
                ST_NHA:  r_num <= w_pn <<< SPLIT;
                ST_NLA:  r_num <= r_num + w_pn;
                ST_NHB:  r_num <= r_num + (w_pn <<< SPLIT);
                ST_NLB:  r_num <= r_num + w_pn;
                default: r_num <= r_num;
            endcase
        end
        if (w_chk) begin
            r_hit <= w_pass;
            r_neg <= r_num[NW-1] ^ r_nz[DW-1];
            r_nq  <= w_num_mag;
            r_den <= w_nz_mag;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (w_div) begin
            r_nq  <= {r_nq[NW-2:0], w_ge};
            r_rem <= w_rem_n[DW-1:0];
            r_cnt <= r_cnt + 7'd1;
        end
        if (w_rnd_en) begin
            r_qm <= w_cap ? bvh_thq_pkg::QCAP_QW : w_qlo[QW-1:0];
        end
        if (w_sum) begin
            if (w_z > (QW+2)'(bvh_thq_pkg::C_MAX)) begin
                r_height <= bvh_thq_pkg::C_MAX;
            end else if (w_z < (QW+2)'(bvh_thq_pkg::C_MIN)) begin
                r_height <= bvh_thq_pkg::C_MIN;
            end else begin
                r_height <= w_z[CW-1:0];
            end
        end
    end

    assign o_res = '{done: r_done, hit: r_hit, height: r_height};

endmodule

`default_nettype wire

FILE: src/bvh_terrain_height_query.sv
// Terrain height query: tree walk over node and triangle memories.
// Usage:
//   One input channel (i_valid / o_stall) carries words of three kinds: a
//   node write, a triangle corner write, and a height query at (x, y). Writes
//   go straight into the node or corner memory and return nothing. A query
//   returns one word on the output channel (o_valid / i_stall): hit flag,
//   highest plane height (saturated Q15.8, zero without a hit) and a flag set
//   when a stack push was dropped or the walk hit its pop limit.
//   Load every node and triangle that a query can reach before querying.
// Walk steps:
//   A query holds o_stall high until its result is in the output register.
//   The walk links the root node, then for each popped node runs a stack check,
//   a stack read and a link; an inner node adds the checks of its two children,
//   whose bounds are read in turn on the single node port. Each leaf triangle
//   is read and run through the 14-step shared multiplier, and one that passes
//   the edge test also through the 80-step restoring divider. A last stack check
//   and a load state close the walk; o_valid rises the cycle after the load.
// Reset clears the walk control and the output valid flag; the memories keep
// their contents and need no clearing. While the receiver stalls, the result
// holds, and a following query finishes its walk and waits to be loaded.
`default_nettype none

module bvh_terrain_height_query #(
    parameter int MAX_NODES     = 4096,
    parameter int MAX_TRIANGLES = 4096,
    parameter int STACK_DEPTH   = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_action,
    input  wire logic [11:0]          i_entry_index,
    input  wire logic [1:0]           i_corner,
    input  wire logic signed [23:0]   i_coord_x,
    input  wire logic signed [23:0]   i_coord_y,
    input  wire logic signed [23:0]   i_coord_z,
    input  wire logic [12:0]          i_leaf_begin,
    input  wire logic [12:0]          i_leaf_stop,
    input  wire logic [11:0]          i_child_pair,
    input  wire logic                 i_split_axis,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_hit_found,
    output logic signed [23:0]        o_height,
    output logic                      o_stack_overflow
);

    localparam int CW  = bvh_thq_pkg::CW;
    localparam int IW  = bvh_thq_pkg::IW;
    localparam int LW  = bvh_thq_pkg::LW;
    localparam int NAW = $clog2(MAX_NODES);
    localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int PCW = $clog2(MAX_NODES + 1);

    bvh_thq_pkg::t_node  r_node_mem [MAX_NODES];
    logic [3*CW-1:0]     r_tri_a_mem [MAX_TRIANGLES];
    logic [3*CW-1:0]     r_tri_b_mem [MAX_TRIANGLES];
    logic [3*CW-1:0]     r_tri_c_mem [MAX_TRIANGLES];
    logic [NAW-1:0]      r_stk_mem [STACK_DEPTH];

    bvh_thq_pkg::t_top_state r_state, n_state;
    bvh_thq_pkg::t_node  r_node_q;
    logic [3*CW-1:0]     r_tri_a_q, r_tri_b_q, r_tri_c_q;
    logic [NAW-1:0]      r_stk_q;
    bvh_thq_pkg::t_coord r_px, r_py, r_best;
    logic [SPW-1:0]      r_sp;
    logic [PCW-1:0]      r_pops;
    logic                r_ovf, r_any;
    logic [IW-1:0]       r_child;
    logic                r_c0ok, r_c1ok;
    logic [LW-1:0]       r_tidx, r_tend;
    logic                r_out_valid, r_out_hit, r_out_ovf;
    bvh_thq_pkg::t_coord r_out_height;

    logic                w_acc, w_query, w_out_free;
    logic                w_node_re, w_stk_re, w_stk_we, w_tri_re, w_tri_start;
    logic [NAW-1:0]      w_node_ra, w_stk_wd;
    logic [SAW-1:0]      w_stk_ra;
    logic [LW-1:0]       w_tri_ra, w_stop_cl, w_tnext;
    logic [SPW-1:0]      w_sp_dec;
    logic [IW:0]         w_cidx;
    bvh_thq_pkg::t_coord w_p;
    logic                w_holds, w_cok, w_push, w_full, w_stack_empty, w_pop_limit;
    logic                w_is_leaf, w_leaf_busy, w_tri_more;
    bvh_thq_pkg::t_node  w_node_wd;
    bvh_thq_pkg::t_tri   w_tri;
    bvh_thq_pkg::t_tri_res w_res;

    assign o_stall    = (r_state != bvh_thq_pkg::S_IDLE);
    assign w_acc      = i_valid && !o_stall;
    assign w_query    = w_acc && (i_action == bvh_thq_pkg::ACT_QUERY);
    assign w_out_free = !r_out_valid || !i_stall;

    // node checks on the word in the node read register
    assign w_p       = r_node_q.axis ? r_py : r_px;
    assign w_holds   = ($signed(r_node_q.lo) <= w_p) && (w_p <= $signed(r_node_q.hi));
    assign w_cidx    = (r_state == bvh_thq_pkg::S_CH1) ? ({1'b0, r_child} + 1'b1)
                                                       : {1'b0, r_child};
    assign w_cok     = (r_state == bvh_thq_pkg::S_CH1) ? r_c1ok : r_c0ok;
    assign w_push    = w_cok && w_holds;
    assign w_full    = 32'(r_sp) >= STACK_DEPTH;
    assign w_stk_wd  = NAW'(w_cidx);
    assign w_sp_dec  = r_sp - 1'b1;
    assign w_stk_ra  = w_sp_dec[SAW-1:0];
    assign w_stack_empty = (r_sp == '0);
    assign w_pop_limit   = 32'(r_pops) >= MAX_NODES;

    assign w_is_leaf   = (r_node_q.child == '0);
    assign w_stop_cl   = (32'(r_node_q.stop) > MAX_TRIANGLES) ? LW'(MAX_TRIANGLES)
                                                              : r_node_q.stop;
    assign w_leaf_busy = r_node_q.first < w_stop_cl;
    assign w_tnext     = r_tidx + 1'b1;
    assign w_tri_more  = w_tnext < r_tend;

    assign w_node_wd = '{axis: i_split_axis, child: i_child_pair, stop: i_leaf_stop,
                         first: i_leaf_begin, hi: i_coord_y, lo: i_coord_x};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bvh_thq_pkg::S_IDLE: if (w_query) n_state = bvh_thq_pkg::S_LINK;
            bvh_thq_pkg::S_LINK: begin
                if (!w_is_leaf) begin
                    n_state = bvh_thq_pkg::S_CH0;
                end else if (w_leaf_busy) begin
                    n_state = bvh_thq_pkg::S_TRD;
                end else begin
                    n_state = bvh_thq_pkg::S_POP;
                end
            end
            bvh_thq_pkg::S_CH0: n_state = bvh_thq_pkg::S_CH1;
            bvh_thq_pkg::S_CH1: n_state = bvh_thq_pkg::S_POP;
            bvh_thq_pkg::S_POP: begin
                if (w_stack_empty || w_pop_limit) begin
                    n_state = bvh_thq_pkg::S_DONE;
                end else begin
                    n_state = bvh_thq_pkg::S_SRD;
                end
            end
            bvh_thq_pkg::S_SRD: n_state = bvh_thq_pkg::S_LINK;
            bvh_thq_pkg::S_TRD: n_state = bvh_thq_pkg::S_TRI;
            bvh_thq_pkg::S_TRI: begin
                if (w_res.done) begin
                    n_state = w_tri_more ? bvh_thq_pkg::S_TRD : bvh_thq_pkg::S_POP;
                end
            end
            bvh_thq_pkg::S_DONE: if (w_out_free) n_state = bvh_thq_pkg::S_IDLE;
            default: n_state = bvh_thq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_node_re   = 1'b0;
        w_node_ra   = '0;
        w_stk_re    = 1'b0;
        w_stk_we    = 1'b0;
        w_tri_re    = 1'b0;
        w_tri_ra    = r_node_q.first;
        w_tri_start = 1'b0;
        unique case (r_state)
            bvh_thq_pkg::S_IDLE: w_node_re = w_query;
            bvh_thq_pkg::S_LINK: begin
                w_node_re = !w_is_leaf;
                w_node_ra = NAW'(r_node_q.child);
                w_tri_re  = w_is_leaf && w_leaf_busy;
            end
            bvh_thq_pkg::S_CH0: begin
                w_node_re = 1'b1;
                w_node_ra = NAW'({1'b0, r_child} + 1'b1);
                w_stk_we  = w_push && !w_full;
            end
            bvh_thq_pkg::S_CH1: w_stk_we = w_push && !w_full;
            bvh_thq_pkg::S_POP: w_stk_re = !w_stack_empty && !w_pop_limit;
            bvh_thq_pkg::S_SRD: begin
                w_node_re = 1'b1;
                w_node_ra = r_stk_q;
            end
            bvh_thq_pkg::S_TRD: w_tri_start = 1'b1;
            bvh_thq_pkg::S_TRI: begin
                w_tri_re = w_res.done && w_tri_more;
                w_tri_ra = w_tnext;
            end
            bvh_thq_pkg::S_DONE: w_node_re = 1'b0;
            default: w_node_re = 1'b0;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_action == bvh_thq_pkg::ACT_NODE) &&
            (32'(i_entry_index) < MAX_NODES)) begin
            r_node_mem[NAW'(i_entry_index)] <= w_node_wd;
        end
        if (w_node_re) begin
            r_node_q <= r_node_mem[w_node_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_action == bvh_thq_pkg::ACT_CORNER) &&
            (32'(i_entry_index) < MAX_TRIANGLES)) begin
            case (i_corner)
                bvh_thq_pkg::CORNER_A:
                    r_tri_a_mem[TAW'(i_entry_index)] <= {i_coord_z, i_coord_y, i_coord_x};
                bvh_thq_pkg::CORNER_B:
                    r_tri_b_mem[TAW'(i_entry_index)] <= {i_coord_z, i_coord_y, i_coord_x};
                bvh_thq_pkg::CORNER_C:
                    r_tri_c_mem[TAW'(i_entry_index)] <= {i_coord_z, i_coord_y, i_coord_x};
                default: ;
            endcase
        end
        if (w_tri_re) begin
            r_tri_a_q <= r_tri_a_mem[TAW'(w_tri_ra)];
            r_tri_b_q <= r_tri_b_mem[TAW'(w_tri_ra)];
            r_tri_c_q <= r_tri_c_mem[TAW'(w_tri_ra)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stk_mem[r_sp[SAW-1:0]] <= w_stk_wd;
        end
        if (w_stk_re) begin
            r_stk_q <= r_stk_mem[w_stk_ra];
        end
    end

    assign w_tri = '{ax: r_tri_a_q[CW-1:0], ay: r_tri_a_q[2*CW-1:CW], az: r_tri_a_q[3*CW-1:2*CW],
                     bx: r_tri_b_q[CW-1:0], by: r_tri_b_q[2*CW-1:CW], bz: r_tri_b_q[3*CW-1:2*CW],
                     cx: r_tri_c_q[CW-1:0], cy: r_tri_c_q[2*CW-1:CW], cz: r_tri_c_q[3*CW-1:2*CW]};

    bvh_thq_tri u_tri (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_tri_start),
        .i_tri   (w_tri),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_res   (w_res)
    );

    // walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bvh_thq_pkg::S_IDLE;
            r_sp        <= '0;
            r_pops      <= '0;
            r_ovf       <= 1'b0;
            r_any       <= 1'b0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_query) begin
                r_sp   <= '0;
                r_pops <= PCW'(1);
                r_ovf  <= 1'b0;
                r_any  <= 1'b0;
                r_best <= '0;
            end
            if ((r_state == bvh_thq_pkg::S_CH0 || r_state == bvh_thq_pkg::S_CH1) && w_push) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_sp <= r_sp + 1'b1;
                end
            end
            if (r_state == bvh_thq_pkg::S_POP && !w_stack_empty) begin
                if (w_pop_limit) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_pops <= r_pops + 1'b1;
                    r_sp   <= w_sp_dec;
                end
            end
            if (r_state == bvh_thq_pkg::S_TRI && w_res.done && w_res.hit) begin
                if (!r_any || ($signed(w_res.height) > r_best)) begin
                    r_best <= w_res.height;
                end
                r_any <= 1'b1;
            end
            if (r_state == bvh_thq_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (r_state == bvh_thq_pkg::S_LINK) begin
            r_child <= r_node_q.child;
            r_c0ok  <= 32'(r_node_q.child) < MAX_NODES;
            r_c1ok  <= (32'(r_node_q.child) + 32'd1) < MAX_NODES;
            r_tidx  <= r_node_q.first;
            r_tend  <= w_stop_cl;
        end
        if (r_state == bvh_thq_pkg::S_TRI && w_res.done) begin
            r_tidx <= w_tnext;
        end
        if (r_state == bvh_thq_pkg::S_DONE && w_out_free) begin
            r_out_hit    <= r_any;
            r_out_height <= r_best;
            r_out_ovf    <= r_ovf;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_hit_found      = r_out_hit;
    assign o_height         = r_out_height;
    assign o_stack_overflow = r_out_ovf;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sp) <= STACK_DEPTH)
        else $error("stack pointer beyond stack depth");

    a_tri_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> (r_state == bvh_thq_pkg::S_TRI))
        else $error("triangle result outside triangle wait");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bvh_thq_pkg::S_DONE && w_out_free) |=> (r_out_valid && !o_stall))
        else $error("finished query not loaded into output register");

endmodule

`default_nettype wire

FILE: tb/bvh_terrain_height_query_test.sv
// Self-checking testbench for the terrain height query block.
`timescale 1ns / 1ps

module bvh_terrain_height_query_test;

    localparam int  N_NODES   = 4096;
    localparam int  N_TRIS    = 4096;
    localparam int  STK_DEPTH = 64;
    localparam int  IDLE_LIMIT = 300000;
    localparam longint HMAX = 64'sd8388607;
    localparam longint HMIN = -64'sd8388608;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [1:0] CORNER_NONE = 2'd3;

    typedef struct {
        logic [1:0]  action;
        logic [11:0] idx;
        logic [1:0]  corner;
        logic [23:0] x, y, z;
        logic [12:0] lb, ls;
        logic [11:0] child;
        logic        axis;
    } t_word;

    typedef struct {
        logic        hit;
        logic [23:0] height;
        logic        ovf;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [1:0] i_action = '0;
    logic [11:0] i_entry_index = '0;
    logic [1:0] i_corner = '0;
    logic signed [23:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic [12:0] i_leaf_begin = '0, i_leaf_stop = '0;
    logic [11:0] i_child_pair = '0;
    logic i_split_axis = 1'b0;
    logic o_stall, o_valid, o_hit_found, o_stack_overflow;
    logic signed [23:0] o_height;

    bvh_terrain_height_query u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the block's memories
    longint bnd_lo [N_NODES];
    longint bnd_hi [N_NODES];
    int     lk_first [N_NODES];
    int     lk_stop  [N_NODES];
    int     lk_child [N_NODES];
    logic   lk_axis  [N_NODES];
    longint crn_x [3*N_TRIS];
    longint crn_y [3*N_TRIS];
    longint crn_z [3*N_TRIS];

    t_answer expected_answers[$];
    int n_errors = 0, n_queries = 0, n_hits = 0, n_ovf = 0, n_writes = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int idle_cycles = 0;
    longint span = 2000;

    function automatic void queue_answer(t_answer a);
        expected_answers = {expected_answers, a};
    endfunction

    function automatic logic tri_height(int t, longint px, longint py, output longint h);
        int k;
        longint ax, ay, az, bx, by, cx, cy;
        longint abx, aby, abz, acx, acy, acz, bcx, bcy, dx, dy, d1, d2, d3, nz, z;
        logic signed [127:0] m1, m2, m3, m4, num;
        logic [127:0] mn, dd, q, r;
        logic neg;
        k = 3 * t;
        ax = crn_x[k];   ay = crn_y[k];   az = crn_z[k];
        bx = crn_x[k+1]; by = crn_y[k+1];
        cx = crn_x[k+2]; cy = crn_y[k+2];
        abx = bx - ax; aby = by - ay; abz = crn_z[k+1] - az;
        acx = cx - ax; acy = cy - ay; acz = crn_z[k+2] - az;
        bcx = cx - bx; bcy = cy - by;
        dx = px - ax; dy = py - ay;
        d1 = aby * dx - abx * dy;
        d2 = bcy * (px - bx) - bcx * (py - by);
        d3 = acx * (py - cy) - acy * (px - cx);
        nz = abx * acy - aby * acx;
        if (!((d1 <= 0 && d2 <= 0 && d3 <= 0) || (d1 >= 0 && d2 >= 0 && d3 >= 0)) || nz == 0)
            return 1'b0;
        m1 = 128'(abz); m2 = 128'(dx * acy - dy * acx);
        m3 = 128'(acz); m4 = 128'(abx * dy - aby * dx);
        num = m1 * m2 + m3 * m4;
        neg = (num < 0) != (nz < 0);
        mn = (num < 0) ? -num : num;
        dd = 128'((nz < 0) ? -nz : nz);
        q = mn / dd;
        r = mn % dd;
        if (2 * r >= dd) q = q + 1;
        if (q > 128'(bvh_thq_pkg::QCAP)) q = 128'(bvh_thq_pkg::QCAP);
        z = az + (neg ? -longint'(q[63:0]) : longint'(q[63:0]));
        h = z > HMAX ? HMAX : (z < HMIN ? HMIN : z);
        return 1'b1;
    endfunction

    function automatic t_answer height_lookup(longint px, longint py);
        int stk[STK_DEPTH];
        int sp, pops, n, c, e;
        longint h, best, p;
        logic hit, ovf;
        t_answer a;
        sp = 1; stk[0] = 0; pops = 0; hit = 0; ovf = 0; best = 0;
        while (sp > 0) begin
            if (pops >= N_NODES) begin
                ovf = 1;
                break;
            end
            pops++;
            sp--;
            n = stk[sp];
            if (lk_child[n] != 0) begin
                for (int j = 0; j < 2; j++) begin
                    c = lk_child[n] + j;
                    if (c < N_NODES) begin
                        p = lk_axis[c] ? py : px;
                        if (bnd_lo[c] <= p && p <= bnd_hi[c]) begin
                            if (sp >= STK_DEPTH) ovf = 1;
                            else begin
                                stk[sp] = c;
                                sp++;
                            end
                        end
                    end
                end
            end else begin
                e = lk_stop[n] > N_TRIS ? N_TRIS : lk_stop[n];
                for (int t = lk_first[n]; t < e; t++) begin
                    if (tri_height(t, px, py, h)) begin
                        if (!hit || h > best) best = h;
                        hit = 1;
                    end
                end
            end
        end
        a.hit = hit;
        a.height = best[23:0];
        a.ovf = ovf;
        return a;
    endfunction

    function automatic void apply_word(t_word w);
        int k;
        case (w.action)
            bvh_thq_pkg::ACT_NODE: begin
                bnd_lo[w.idx] = longint'($signed(w.x));
                bnd_hi[w.idx] = longint'($signed(w.y));
                lk_first[w.idx] = int'(w.lb);
                lk_stop[w.idx] = int'(w.ls);
                lk_child[w.idx] = int'(w.child);
                lk_axis[w.idx] = w.axis;
                n_writes++;
            end
            bvh_thq_pkg::ACT_CORNER: begin
                if (w.corner != CORNER_NONE) begin
                    k = 3 * w.idx + w.corner;
                    crn_x[k] = longint'($signed(w.x));
                    crn_y[k] = longint'($signed(w.y));
                    crn_z[k] = longint'($signed(w.z));
                    n_writes++;
                end
            end
            bvh_thq_pkg::ACT_QUERY: begin
                queue_answer(height_lookup(longint'($signed(w.x)), longint'($signed(w.y))));
                n_queries++;
            end
            default: ;
        endcase
    endfunction

    function automatic t_word noise_word();
        t_word w;
        w.action = 2'($urandom_range(0, 3));
        w.idx = 12'($urandom);
        w.corner = 2'($urandom);
        w.x = 24'($urandom); w.y = 24'($urandom); w.z = 24'($urandom);
        w.lb = 13'($urandom); w.ls = 13'($urandom);
        w.child = 12'($urandom);
        w.axis = 1'($urandom);
        return w;
    endfunction

    task automatic send_word(t_word w);
        i_valid <= 1'b1;
        i_action <= w.action;
        i_entry_index <= w.idx;
        i_corner <= w.corner;
        i_coord_x <= w.x;
        i_coord_y <= w.y;
        i_coord_z <= w.z;
        i_leaf_begin <= w.lb;
        i_leaf_stop <= w.ls;
        i_child_pair <= w.child;
        i_split_axis <= w.axis;
        do @(posedge i_clk); while (o_stall);
        apply_word(w);
    endtask

    // bursts of random length separated by random gaps
    task automatic paced_send(t_word w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(1, 10));
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = int'($urandom_range(1, 16));
        end
        burst_left--;
        send_word(w);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_answers.size() != 0);
    endtask

    task automatic put_node(int idx, longint lo, longint hi, int first, int stop,
                            int child, logic axis);
        t_word w = noise_word();
        w.action = bvh_thq_pkg::ACT_NODE; w.idx = 12'(idx);
        w.x = lo[23:0]; w.y = hi[23:0];
        w.lb = 13'(first); w.ls = 13'(stop); w.child = 12'(child); w.axis = axis;
        paced_send(w);
    endtask

    task automatic put_tri(int idx, longint ax, longint ay, longint az, longint bx,
                           longint by, longint bz, longint cx, longint cy, longint cz);
        t_word w = noise_word();
        w.action = bvh_thq_pkg::ACT_CORNER; w.idx = 12'(idx);
        w.corner = bvh_thq_pkg::CORNER_A; w.x = ax[23:0]; w.y = ay[23:0]; w.z = az[23:0];
        paced_send(w);
        w.corner = bvh_thq_pkg::CORNER_B; w.x = bx[23:0]; w.y = by[23:0]; w.z = bz[23:0];
        paced_send(w);
        w.corner = bvh_thq_pkg::CORNER_C; w.x = cx[23:0]; w.y = cy[23:0]; w.z = cz[23:0];
        paced_send(w);
    endtask

    task automatic query_at(longint x, longint y);
        t_word w = noise_word();
        w.action = bvh_thq_pkg::ACT_QUERY; w.x = x[23:0]; w.y = y[23:0];
        paced_send(w);
    endtask

    function automatic longint coord_in_span();
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // binary tree over nodes 0..62, leaves use triangles 0..63
    task automatic build_scene();
        longint lo, hi;
        int first;
        for (int n = 0; n < 63; n++) begin
            lo = coord_in_span();
            hi = lo + longint'($urandom_range(0, 32'(2 * span)));
            if ($urandom_range(0, 4) == 0) begin
                lo = HMIN;
                hi = HMAX;
            end
            first = int'($urandom_range(0, 62));
            put_node(n, lo, hi, first, first + int'($urandom_range(0, 2)),
                     (n < 31 && $urandom_range(0, 5) != 0) ? 2 * n + 1 : 0,
                     1'($urandom_range(0, 1)));
        end
        for (int t = 0; t < 64; t++)
            put_tri(t, coord_in_span(), coord_in_span(), coord_in_span(),
                    coord_in_span(), coord_in_span(), coord_in_span(),
                    coord_in_span(), coord_in_span(), coord_in_span());
    endtask

    task automatic test_edges_and_ranges();
        // root points at the top pair; one leaf has a clamped range, one is empty
        put_node(0, 0, 0, 0, 0, 4094, 1'b0);
        put_node(4094, HMIN, HMAX, 4090, 8191, 0, 1'b1);
        put_node(4095, -100, 100, 4096, 0, 0, 1'b0);
        put_tri(4090, -1000, -1000, 0, 1000, -1000, 256, -1000, 1000, -256);
        put_tri(4091, 0, 0, 500, 10, 10, 500, 20, 20, 500);            // collinear
        put_tri(4092, 0, 0, 2000, 0, 200, 2000, 200, 0, 2000);         // other winding
        put_tri(4093, HMIN, HMIN, HMAX, HMAX, HMIN, HMIN, HMIN, HMAX, HMIN);
        put_tri(4094, 5, 5, 7, 6, 5, 3, 5, 6, 1);
        put_tri(4095, 3000, 3000, 1, 3001, 3000, 1, 3000, 3001, 1);
        query_at(0, 0);
        query_at(200, 0);
        query_at(100, 100);
        query_at(101, 100);
        query_at(5, 5);
        query_at(-1000, 1000);
        query_at(HMAX, HMAX);
        query_at(HMIN, HMIN);
        query_at(3, -999);
        wait_drain();
    endtask

    task automatic test_overflow_and_ignored();
        t_word w;
        // self-referencing pairs grow the stack until it overflows
        put_node(0, 0, 0, 0, 0, 1, 1'b0);
        put_node(1, HMIN, HMAX, 0, 0, 1, 1'b0);
        put_node(2, -50, 50, 0, 0, 1, 1'b1);
        query_at(0, 0);
        query_at(0, 60);
        w = noise_word();
        w.action = ACT_NONE;
        paced_send(w);
        w = noise_word();
        w.action = bvh_thq_pkg::ACT_CORNER; w.corner = CORNER_NONE; w.idx = 12'd4090;
        paced_send(w);
        query_at(0, 51);
        wait_drain();
    endtask

    task automatic test_random_walks(int n_items);
        t_word w;
        build_scene();
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    // content the walk never reaches
                    w = noise_word();
                    if (w.action == bvh_thq_pkg::ACT_NODE)
                        w.idx = 12'($urandom_range(64, 4093));
                    if (w.action == bvh_thq_pkg::ACT_CORNER)
                        w.idx = 12'($urandom_range(64, 4089));
                    if (w.action == bvh_thq_pkg::ACT_QUERY && $urandom_range(0, 1)) begin
                        w.x = HMIN[23:0];
                        w.y = HMAX[23:0];
                    end
                    paced_send(w);
                end
                1: put_tri(int'($urandom_range(0, 63)), coord_in_span(), coord_in_span(),
                           coord_in_span(), coord_in_span(), coord_in_span(),
                           coord_in_span(), coord_in_span(), coord_in_span(),
                           coord_in_span());
                default: query_at(coord_in_span(), coord_in_span());
            endcase
            if (i % 150 == 149) wait_drain();
        end
        wait_drain();
    endtask

    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 2));
    end

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_answers.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result word: hit=%0b height=%0d ovf=%0b",
                             o_hit_found, o_height, o_stack_overflow);
            end else begin
                e = expected_answers.pop_front();
                if (e.hit) n_hits++;
                if (e.ovf) n_ovf++;
                if (o_hit_found !== e.hit || o_height !== e.height
                        || o_stack_overflow !== e.ovf) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp hit=%0b height=%0d ovf=%0b, got hit=%0b height=%0d ovf=%0b",
                                 e.hit, $signed(e.height), e.ovf,
                                 o_hit_found, o_height, o_stack_overflow);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_answers.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges_and_ranges();
        test_overflow_and_ignored();
        span = 2000;
        test_random_walks(250);
        span = 12;
        test_random_walks(170);
        i_valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d queries (%0d hits, %0d overflows) and %0d store writes",
                 n_queries, n_hits, n_ovf, n_writes);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/bvh_thq_pkg.sv
src/bvh_thq_tri.sv
src/bvh_terrain_height_query.sv
tb/bvh_terrain_height_query_test.sv
